/* sv/csr_pkg.sv */
// Shared constants and the CORDIC angle table for the c-phi strength reduction unit.
// Used by every module of the block except csr_delay; depends on nothing.
package csr_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 20;

  localparam int C_W    = 32;  // cohesion, Q16 signed
  localparam int PHI_W  = 24;  // friction angle, Q16 degrees signed
  localparam int F_W    = 24;  // safety factor, Q16 unsigned
  localparam int RC_W   = 31;  // reduced cohesion
  localparam int RA_W   = 23;  // reduced angle
  localparam int ST_W   = 2;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 56;

  // CORDIC datapath widths
  localparam int ROT_W = 33;   // rotation x/y, Q30
  localparam int VEC_W = 58;   // vectoring x/y, Q46
  localparam int ANG_W = 42;   // angle accumulator, Q32 degrees

  // divider: 48-bit dividend, one quotient bit per cell
  localparam int DIV_BITS = 32;
  localparam int REM_W    = F_W;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_ANGLE   = 2'd1;
  localparam logic [ST_W-1:0] ST_NEG_C   = 2'd2;
  localparam logic [ST_W-1:0] ST_F_LOW   = 2'd3;

  localparam logic [PHI_W-1:0] DEG90_Q16 = 24'd5898240;
  localparam logic [F_W-1:0]   ONE_Q16   = 24'd65536;
  localparam logic [63:0]      DEG_PER_RAD_Q26 = 64'd3845054675;

  // atan(2^-i) in degrees, Q32, from the arctangent series in Q62
  function automatic logic [63:0] atan_q32(input int unsigned i);
    logic [63:0] rad;
    logic [63:0] term;
    int unsigned e;
    rad = 64'd0;
    if (i == 0) begin
      return 64'd45 << 32;
    end
    for (int unsigned k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        if (k[0]) begin
          rad = rad - term;
        end else begin
          rad = rad + term;
        end
      end
    end
    return ((rad >> 30) * DEG_PER_RAD_Q26) >> 26;
  endfunction

endpackage

/* sv/csr_delay.sv */
// Enable-gated delay line that keeps side data aligned with the cell chains.
// Depends on nothing.
module csr_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  generate
    if (DEPTH == 0) begin : g_none
      assign dout = din;
    end else begin : g_line
      logic [W-1:0] tap_r [DEPTH];
      always_ff @(posedge clk) begin
        if (en) begin
          tap_r[0] <= din;
          for (int k = 1; k < DEPTH; k++) begin
            tap_r[k] <= tap_r[k-1];
          end
        end
      end
      assign dout = tap_r[DEPTH-1];
    end
  endgenerate

endmodule

/* sv/csr_rot_cell.sv */
// One rotation-mode CORDIC micro-rotation, registered.
// Depends on csr_pkg for widths and the angle table.
module csr_rot_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [csr_pkg::ROT_W-1:0] x_in,
  input  logic signed [csr_pkg::ROT_W-1:0] y_in,
  input  logic signed [csr_pkg::ANG_W-1:0] z_in,
  output logic signed [csr_pkg::ROT_W-1:0] x_r,
  output logic signed [csr_pkg::ROT_W-1:0] y_r,
  output logic signed [csr_pkg::ANG_W-1:0] z_r
);

  localparam logic [63:0] TAB64 = csr_pkg::atan_q32(IDX);
  localparam logic signed [csr_pkg::ANG_W-1:0] TAB = TAB64[csr_pkg::ANG_W-1:0];

  logic signed [csr_pkg::ROT_W-1:0] dx, dy;
  logic signed [csr_pkg::ROT_W-1:0] x_nxt, y_nxt;
  logic signed [csr_pkg::ANG_W-1:0] z_nxt;

  always_comb begin
    dx = y_in >>> IDX;
    dy = x_in >>> IDX;
    if (!z_in[csr_pkg::ANG_W-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - TAB;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + TAB;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

/* sv/csr_vec_cell.sv */
// One vectoring-mode CORDIC micro-rotation, registered.
// Depends on csr_pkg for widths and the angle table.
module csr_vec_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [csr_pkg::VEC_W-1:0] x_in,
  input  logic signed [csr_pkg::VEC_W-1:0] y_in,
  input  logic signed [csr_pkg::ANG_W-1:0] z_in,
  output logic signed [csr_pkg::VEC_W-1:0] x_r,
  output logic signed [csr_pkg::VEC_W-1:0] y_r,
  output logic signed [csr_pkg::ANG_W-1:0] z_r
);

  localparam logic [63:0] TAB64 = csr_pkg::atan_q32(IDX);
  localparam logic signed [csr_pkg::ANG_W-1:0] TAB = TAB64[csr_pkg::ANG_W-1:0];

  logic signed [csr_pkg::VEC_W-1:0] dx, dy;
  logic signed [csr_pkg::VEC_W-1:0] x_nxt, y_nxt;
  logic signed [csr_pkg::ANG_W-1:0] z_nxt;

  always_comb begin
    dx = y_in >>> IDX;
    dy = x_in >>> IDX;
    if (!y_in[csr_pkg::VEC_W-1]) begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + TAB;
    end else begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - TAB;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

/* sv/csr_div_cell.sv */
// One restoring-division step: yields one quotient bit per cycle while en is high.
// Depends on csr_pkg for widths.
module csr_div_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [csr_pkg::F_W-1:0]           f_in,
  input  logic [csr_pkg::REM_W-1:0]         rem_in,
  input  logic [csr_pkg::DIV_BITS-1:0]      dl_in,
  input  logic [csr_pkg::DIV_BITS-1:0]      q_in,
  output logic [csr_pkg::F_W-1:0]           f_r,
  output logic [csr_pkg::REM_W-1:0]         rem_r,
  output logic [csr_pkg::DIV_BITS-1:0]      dl_r,
  output logic [csr_pkg::DIV_BITS-1:0]      q_r
);

  logic [csr_pkg::REM_W:0]   trial;
  logic [csr_pkg::REM_W:0]   diff;
  logic                      qbit;
  logic [csr_pkg::REM_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_in, dl_in[csr_pkg::DIV_BITS-1]};
    diff    = trial - {1'b0, f_in};
    qbit    = (trial >= {1'b0, f_in});
    rem_nxt = qbit ? diff[csr_pkg::REM_W-1:0] : trial[csr_pkg::REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r   <= f_in;
      rem_r <= rem_nxt;
      dl_r  <= {dl_in[csr_pkg::DIV_BITS-2:0], 1'b0};
      q_r   <= {q_in[csr_pkg::DIV_BITS-2:0], qbit};
    end
  end

endmodule

/* sv/c_phi_strength_reduction_unit.sv */
// Mohr-Coulomb c-phi strength reduction: c/F and atan(tan(phi)/F), Q16 fixed point.
// Depends on csr_pkg, csr_delay, csr_rot_cell, csr_vec_cell and csr_div_cell.
//
// Fully pipelined: one item is accepted per cycle unless the skid entry is full,
// and its result leaves through the output register. The angle runs through a row
// of rotation cells, one multiply stage and a row of vectoring cells; the
// cohesion runs in parallel through 32 restoring divider cells, one quotient
// bit each. An output register plus a skid entry take results while the sink
// stalls; in_tready drops only once the skid entry is occupied. On an input
// error both results are zero and status holds the first check that failed.
module c_phi_strength_reduction_unit #(
  parameter int CORDIC_ITERATIONS = csr_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // cohesion[31:0], phi_deg[55:32], safety_factor[79:56]
  input  logic [csr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // reduced_cohesion[30:0], reduced_angle[53:31], status[55:54]
  output logic [csr_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int N     = CORDIC_ITERATIONS;
  localparam int A_LAT = 2 * N + 1;
  localparam int D_LAT = csr_pkg::DIV_BITS;
  localparam int LAT   = (A_LAT > D_LAT) ? A_LAT : D_LAT;
  localparam int ROT_W = csr_pkg::ROT_W;
  localparam int VEC_W = csr_pkg::VEC_W;
  localparam int ANG_W = csr_pkg::ANG_W;
  localparam int SIDE_W = csr_pkg::ST_W + 1;

  logic en;

  // ---------------- input stage ----------------
  logic signed [csr_pkg::C_W-1:0]   c_in;
  logic signed [csr_pkg::PHI_W-1:0] phi_in;
  logic [csr_pkg::F_W-1:0]          f_in;
  logic [csr_pkg::ST_W-1:0]         st_nxt;

  assign c_in   = in_tdata[31:0];
  assign phi_in = in_tdata[55:32];
  assign f_in   = in_tdata[79:56];

  always_comb begin
    if (phi_in < 0 || phi_in > $signed({1'b0, csr_pkg::DEG90_Q16})) begin
      st_nxt = csr_pkg::ST_ANGLE;
    end else if (c_in < 0) begin
      st_nxt = csr_pkg::ST_NEG_C;
    end else if (f_in < csr_pkg::ONE_Q16) begin
      st_nxt = csr_pkg::ST_F_LOW;
    end else begin
      st_nxt = csr_pkg::ST_OK;
    end
  end

  logic [csr_pkg::C_W-1:0]          c_r;
  logic signed [csr_pkg::PHI_W-1:0] phi_r;
  logic [csr_pkg::F_W-1:0]          f_r;
  logic [csr_pkg::ST_W-1:0]         st_r;
  logic                             vld_r [LAT+1];

  always_ff @(posedge clk) begin
    if (en) begin
      c_r   <= c_in;
      phi_r <= phi_in;
      f_r   <= f_in;
      st_r  <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k <= LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---------------- rotation chain ----------------
  logic signed [ROT_W-1:0] rx [N+1];
  logic signed [ROT_W-1:0] ry [N+1];
  logic signed [ANG_W-1:0] rz [N+1];

  assign rx[0] = ROT_W'(1) <<< 30;
  assign ry[0] = '0;
  assign rz[0] = ANG_W'(phi_r) <<< 16;

  for (genvar i = 0; i < N; i++) begin : g_rot
    csr_rot_cell #(.IDX(i)) u_rot (
      .clk(clk), .en(en),
      .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]),
      .x_r(rx[i+1]), .y_r(ry[i+1]), .z_r(rz[i+1])
    );
  end

  logic [csr_pkg::F_W-1:0] f_rot;
  csr_delay #(.W(csr_pkg::F_W), .DEPTH(N)) u_fdly (
    .clk(clk), .en(en), .din(f_r), .dout(f_rot)
  );

  // ---------------- scale stage ----------------
  logic [ROT_W-2:0]        cos_pos;
  logic signed [VEC_W-1:0] vx [N+1];
  logic signed [VEC_W-1:0] vy [N+1];
  logic signed [ANG_W-1:0] vz [N+1];
  logic signed [VEC_W-1:0] mx_r, my_r;

  assign cos_pos = rx[N][ROT_W-1] ? '0 : rx[N][ROT_W-2:0];

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= $signed(VEC_W'(cos_pos * f_rot));
      my_r <= VEC_W'(ry[N]) <<< 16;
    end
  end

  assign vx[0] = mx_r;
  assign vy[0] = my_r;
  assign vz[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    csr_vec_cell #(.IDX(i)) u_vec (
      .clk(clk), .en(en),
      .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
      .x_r(vx[i+1]), .y_r(vy[i+1]), .z_r(vz[i+1])
    );
  end

  logic signed [ANG_W-1:0] ang_al;
  csr_delay #(.W(ANG_W), .DEPTH(LAT - A_LAT)) u_adly (
    .clk(clk), .en(en), .din(vz[N]), .dout(ang_al)
  );

  // ---------------- divider chain ----------------
  localparam int DVD_W = csr_pkg::C_W + 16;
  logic [DVD_W-1:0] dividend;
  assign dividend = {c_r, 16'd0} + DVD_W'(f_r >> 1);

  logic [csr_pkg::F_W-1:0]      df   [D_LAT+1];
  logic [csr_pkg::REM_W-1:0]    drem [D_LAT+1];
  logic [csr_pkg::DIV_BITS-1:0] ddl  [D_LAT+1];
  logic [csr_pkg::DIV_BITS-1:0] dq   [D_LAT+1];

  assign df[0]   = f_r;
  assign drem[0] = csr_pkg::REM_W'(dividend[DVD_W-1:csr_pkg::DIV_BITS]);
  assign ddl[0]  = dividend[csr_pkg::DIV_BITS-1:0];
  assign dq[0]   = '0;

  for (genvar i = 0; i < D_LAT; i++) begin : g_div
    csr_div_cell u_div (
      .clk(clk), .en(en),
      .f_in(df[i]), .rem_in(drem[i]), .dl_in(ddl[i]), .q_in(dq[i]),
      .f_r(df[i+1]), .rem_r(drem[i+1]), .dl_r(ddl[i+1]), .q_r(dq[i+1])
    );
  end

  logic [csr_pkg::DIV_BITS-1:0] q_al;
  csr_delay #(.W(csr_pkg::DIV_BITS), .DEPTH(LAT - D_LAT)) u_qdly (
    .clk(clk), .en(en), .din(dq[D_LAT]), .dout(q_al)
  );

  // status and zero-angle flag travel alongside
  logic [SIDE_W-1:0] side_al;
  csr_delay #(.W(SIDE_W), .DEPTH(LAT)) u_sdly (
    .clk(clk), .en(en), .din({phi_r == '0, st_r}), .dout(side_al)
  );

  // ---------------- result formatting ----------------
  logic signed [ANG_W-1:0]          zr;
  logic signed [ANG_W-17:0]         rnd;
  logic [csr_pkg::RA_W-1:0]         ra;
  logic [csr_pkg::RC_W-1:0]         rc;
  logic [csr_pkg::ST_W-1:0]         st_fin;
  logic [csr_pkg::OUT_TDATA_W-1:0]  res;

  always_comb begin
    st_fin = side_al[csr_pkg::ST_W-1:0];
    zr     = ang_al + ANG_W'(32768);
    rnd    = zr[ANG_W-1:16];
    if (rnd < 0 || side_al[SIDE_W-1]) begin
      ra = '0;
    end else if (rnd > $signed((ANG_W-16)'(csr_pkg::DEG90_Q16))) begin
      ra = csr_pkg::DEG90_Q16[csr_pkg::RA_W-1:0];
    end else begin
      ra = rnd[csr_pkg::RA_W-1:0];
    end
    rc = q_al[csr_pkg::RC_W-1:0];
    if (st_fin != csr_pkg::ST_OK) begin
      ra = '0;
      rc = '0;
    end
    res = {st_fin, ra, rc};
  end

  // ---------------- output register and skid ----------------
  logic                            out_valid_r, skid_full_r;
  logic [csr_pkg::OUT_TDATA_W-1:0] out_data_r, skid_data_r;

  assign en         = !skid_full_r;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_tready) begin
        skid_full_r <= 1'b0;
      end
    end else if (vld_r[LAT]) begin
      if (out_valid_r && !out_tready) begin
        skid_full_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (vld_r[LAT]) begin
      if (out_valid_r && !out_tready) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

endmodule

/* test/tb_c_phi_strength_reduction_unit.sv */
// Testbench for c_phi_strength_reduction_unit: Q16 c/F and atan(tan(phi)/F).
// Uses csr_pkg for widths and status codes; the expected values come from an
// independent bit-exact CORDIC and divider model kept in this file.
`timescale 1ns / 1ps

module tb_c_phi_strength_reduction_unit;

  localparam int ITERS       = csr_pkg::CORDIC_ITERATIONS_DEF;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [csr_pkg::ST_W-1:0] status;
    logic [csr_pkg::RA_W-1:0] angle;
    logic [csr_pkg::RC_W-1:0] cohesion;
  } strength_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [csr_pkg::IN_TDATA_W-1:0]  in_tdata;   // cohesion, phi_deg, safety_factor
  logic                            out_tvalid;
  logic                            out_tready;
  logic [csr_pkg::OUT_TDATA_W-1:0] out_tdata;  // reduced_cohesion, reduced_angle, status

  strength_t reduced_q[$];
  longint    atan_tab[32];
  int        fail_cnt;
  int        items_sent;
  int        results_seen;
  int        errors_sent;
  int        idle_cnt;
  bit        idle_en;
  int        hold_cycles;

  c_phi_strength_reduction_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // atan(2^-i) in Q32 degrees from the Q62 series
  function automatic longint atan_entry(int unsigned i);
    longint unsigned rad;
    longint unsigned term;
    int unsigned e;
    rad = 0;
    if (i == 0) return longint'(45) <<< 32;
    for (int unsigned k = 0; k < 40; k++) begin
      e = i * (2 * k + 1);
      if (e > 62) break;
      term = (64'd1 << (62 - e)) / longint'(2 * k + 1);
      if (k[0]) rad = rad - term;
      else rad = rad + term;
    end
    return longint'(((rad >> 30) * 64'd3845054675) >> 26);
  endfunction

  function automatic longint reduced_angle_of(longint phi, longint f);
    longint x, y, z, dx, dy, r;
    x = longint'(1) <<< 30;
    y = 0;
    z = phi * 65536;
    if (phi == 0) return 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin x -= dx; y += dy; z -= atan_tab[i]; end
      else begin x += dx; y -= dy; z += atan_tab[i]; end
    end
    if (x < 0) x = 0;  // near ninety degrees the cosine can go slightly negative
    x = x * f;
    y = y * 65536;
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin x += dx; y -= dy; z += atan_tab[i]; end
      else begin x -= dx; y += dy; z -= atan_tab[i]; end
    end
    r = (z + 32768) >>> 16;
    if (r < 0) r = 0;
    if (r > longint'(csr_pkg::DEG90_Q16)) r = longint'(csr_pkg::DEG90_Q16);
    return r;
  endfunction

  function automatic strength_t reduce_strength(logic signed [csr_pkg::C_W-1:0] c,
                                                logic signed [csr_pkg::PHI_W-1:0] phi,
                                                logic [csr_pkg::F_W-1:0] f);
    strength_t res;
    longint cl, pl, fl;
    cl = longint'(c);
    pl = longint'(phi);
    fl = longint'({40'd0, f});
    res = '0;
    if (pl < 0 || pl > longint'(csr_pkg::DEG90_Q16)) res.status = csr_pkg::ST_ANGLE;
    else if (cl < 0) res.status = csr_pkg::ST_NEG_C;
    else if (fl < longint'(csr_pkg::ONE_Q16)) res.status = csr_pkg::ST_F_LOW;
    else res.status = csr_pkg::ST_OK;
    if (res.status == csr_pkg::ST_OK) begin
      res.cohesion = csr_pkg::RC_W'(((cl <<< 16) + (fl >>> 1)) / fl);
      res.angle    = csr_pkg::RA_W'(reduced_angle_of(pl, fl));
    end
    return res;
  endfunction

  task automatic send_item(logic [csr_pkg::C_W-1:0] c, logic [csr_pkg::PHI_W-1:0] phi,
                           logic [csr_pkg::F_W-1:0] f);
    strength_t exp_res;
    if (idle_en && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {f, phi, c};
    do @(posedge clk); while (!in_tready);
    exp_res = reduce_strength(c, phi, f);
    reduced_q.push_back(exp_res);
    items_sent++;
    if (exp_res.status != csr_pkg::ST_OK) errors_sent++;
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    while (reduced_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_item();
    logic [csr_pkg::C_W-1:0]   c;
    logic [csr_pkg::PHI_W-1:0] phi;
    logic [csr_pkg::F_W-1:0]   f;
    if ($urandom_range(99) < 70) begin
      c   = $urandom_range(32'h7fff_ffff, 0);
      phi = $urandom_range(csr_pkg::DEG90_Q16, 0);
      case ($urandom_range(3))
        0: f = $urandom_range(2 * csr_pkg::ONE_Q16, csr_pkg::ONE_Q16);
        1: f = $urandom_range(24'hff_ffff, csr_pkg::ONE_Q16);
        default: f = $urandom_range(10 * csr_pkg::ONE_Q16, csr_pkg::ONE_Q16);
      endcase
      if ($urandom_range(9) == 0) c = $urandom_range(65535, 0);
    end else begin
      c   = $urandom;
      phi = $urandom;
      f   = $urandom;
    end
    send_item(c, phi, f);
  endtask

  task automatic test_directed();
    send_item(32'd65536, 24'd0, csr_pkg::ONE_Q16);                     // zero angle
    send_item(32'd65536, csr_pkg::DEG90_Q16, csr_pkg::ONE_Q16);        // ninety degrees
    send_item(32'd65536, csr_pkg::DEG90_Q16, 24'hff_ffff);
    send_item(32'h7fff_ffff, csr_pkg::DEG90_Q16 - 24'd1, 24'd65537);
    send_item(32'h7fff_ffff, 24'd1, csr_pkg::ONE_Q16);
    send_item(32'd0, 24'd1966080, 24'd131072);
    send_item(32'd1, 24'd2949120, 24'hff_ffff);
    send_item(32'd12345678, 24'd1966080, 24'd98304);
    send_item(32'd100, csr_pkg::DEG90_Q16 + 24'd1, csr_pkg::ONE_Q16);  // angle just above range
    send_item(32'd100, 24'hff_ffff, csr_pkg::ONE_Q16);                 // angle -1 lsb
    send_item(32'd100, 24'h80_0000, csr_pkg::ONE_Q16);
    send_item(32'd100, 24'h7f_ffff, csr_pkg::ONE_Q16);
    send_item(32'hffff_ffff, 24'd65536, csr_pkg::ONE_Q16);             // negative cohesion
    send_item(32'h8000_0000, 24'd65536, csr_pkg::ONE_Q16);
    send_item(32'hffff_ffff, 24'h80_0000, 24'd0);                      // angle check wins
    send_item(32'd100, 24'd65536, 24'd65535);                          // factor below one
    send_item(32'd100, 24'd65536, 24'd0);
    send_item(32'h8000_0000, 24'd65536, 24'd0);                        // cohesion check wins
    send_item(32'd0, 24'd0, 24'd0);
    send_item(32'h7fff_ffff, csr_pkg::DEG90_Q16, 24'hff_ffff);
    pause_until_drained();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) idle_en = 1'b0;  // long stretch with no idling
      if (i == n / 3 + 300) idle_en = 1'b1;
      send_random_item();
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 120; i++) send_random_item();
    pause_until_drained();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_en && $urandom_range(99) < 7) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    strength_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (reduced_q.size() == 0) begin
        $error("result with no item outstanding: %h", out_tdata);
        fail_cnt++;
      end else begin
        want = reduced_q.pop_front();
        if (got.cohesion !== want.cohesion) begin
          $error("reduced_cohesion: expected %0d, got %0d", want.cohesion, got.cohesion);
          fail_cnt++;
        end
        if (got.angle !== want.angle) begin
          $error("reduced_angle: expected %0d, got %0d", want.angle, got.angle);
          fail_cnt++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("tb_c_phi_strength_reduction_unit failed");
      $finish;
    end
  end

  initial begin
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    rst_n        = 1'b0;
    fail_cnt     = 0;
    items_sent   = 0;
    results_seen = 0;
    errors_sent  = 0;
    idle_cnt     = 0;
    idle_en      = 1'b1;
    hold_cycles  = 0;
    for (int i = 0; i < 32; i++) atan_tab[i] = atan_entry(i);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random(800);
    test_backpressure();
    test_random(760);
    pause_until_drained();
    repeat (80) @(negedge clk);
    $display("Covered %0d items (%0d rejected by input checks), %0d results checked,",
             items_sent, errors_sent, results_seen);
    $display("with random idling, a no-idle stretch and a long output hold.");
    if (fail_cnt == 0 && reduced_q.size() == 0) begin
      $display("tb_c_phi_strength_reduction_unit passed");
    end else begin
      $display("tb_c_phi_strength_reduction_unit failed");
    end
    $finish;
  end

endmodule
